// File: sv/lbg_pkg.sv
// Package for the LCD bar-graph glyph generator: widths, codes and glyph lookup.
`default_nettype none
package lbg_pkg;

  // Defaults for the top-level parameters
  localparam int MaxCellsDef    = 16;
  localparam int CellColumnsDef = 5;

  // Field widths
  localparam int LevelW  = 8;
  localparam int GlyphW  = 8;
  localparam int CellIdxW = 4;
  localparam int CountW  = 5;
  localparam int GlyphsW = 40;
  localparam int GlyphBytes = GlyphsW / GlyphW;
  localparam int CfgDataW = GlyphsW;

  // Threshold width: every threshold stays at or below full scale
  localparam int ThrW = 9;

  // Restoring divider steps, one quotient bit per cycle
  localparam int DivSteps = LevelW;

  // Reset values of the registers
  localparam logic [LevelW-1:0]  FullScaleRst  = 8'd255;
  localparam logic [CountW-1:0]  CellCountRst  = 5'd16;
  localparam logic [GlyphW-1:0]  EmptyGlyphRst = 8'd32;
  localparam logic [GlyphsW-1:0] LevelGlyphsRst = 40'h04_0302_0100;

  typedef enum logic [1:0] {
    REG_FULL_SCALE   = 2'd0,
    REG_CELL_COUNT   = 2'd1,
    REG_EMPTY_GLYPH  = 2'd2,
    REG_LEVEL_GLYPHS = 2'd3
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_SETUP,
    ST_EMIT
  } lbg_state_e;

  // Glyph for b+1 filled columns; bytes beyond the register read zero
  function automatic logic [GlyphW-1:0] glyph_sel(input logic [GlyphsW-1:0] glyphs,
                                                  input logic [3:0] b);
    logic [GlyphW-1:0] g;
    g = '0;
    if (int'(b) < GlyphBytes) begin
      g = glyphs[GlyphW*int'(b) +: GlyphW];
    end
    return g;
  endfunction

endpackage
`default_nettype wire

// File: sv/lcd_bar_graph_glyphs.sv
// Top level: level value to a row of character-LCD bar-graph glyph codes.
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+------------------------------------------
//  input    | in_valid_i / in_ready_o    | level_i
//  output   | out_valid_o / out_ready_i  | cell_glyph_o, cell_index_o, last_cell_o
//  config   | cfg_we_i (no wait)         | cfg_idx_i, cfg_data_i
//
// One transaction in gives n output transactions, n = cell_count clamped to
// MAX_CELLS (none for a zero count). A transaction runs through accept, 8
// divider steps, setup and then the n cells; the shared restoring subtractor
// does one step per cycle, the emitter one cell per cycle unless the output stalls.
// A stalled output holds the emitter; the next input is taken once the
// sequencer is back in idle, even while the last cell still waits.
// Reset brings the configuration registers to their defaults and empties the output stage.
`default_nettype none
module lcd_bar_graph_glyphs #(
  parameter int MAX_CELLS    = lbg_pkg::MaxCellsDef,
  parameter int CELL_COLUMNS = lbg_pkg::CellColumnsDef
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  // configuration
  input  wire logic                        cfg_we_i,
  input  wire logic [1:0]                  cfg_idx_i,
  input  wire logic [lbg_pkg::CfgDataW-1:0] cfg_data_i,
  // input
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire logic [lbg_pkg::LevelW-1:0]  level_i,
  // output
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic [lbg_pkg::GlyphW-1:0]       cell_glyph_o,
  output logic [lbg_pkg::CellIdxW-1:0]     cell_index_o,
  output logic                             last_cell_o
);
  import lbg_pkg::*;

  localparam int NW    = $clog2(MAX_CELLS + 1);
  localparam int SpanW = $clog2(MAX_CELLS * CELL_COLUMNS + 1);
  localparam int BW    = (CELL_COLUMNS > 1) ? $clog2(CELL_COLUMNS) : 1;
  localparam int CntW  = $clog2(DivSteps);

  // Configuration registers
  logic [LevelW-1:0]  cfg_full_scale_q;
  logic [CountW-1:0]  cfg_cell_count_q;
  logic [GlyphW-1:0]  cfg_empty_glyph_q;
  logic [GlyphsW-1:0] cfg_level_glyphs_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_full_scale_q   <= FullScaleRst;
      cfg_cell_count_q   <= CellCountRst;
      cfg_empty_glyph_q  <= EmptyGlyphRst;
      cfg_level_glyphs_q <= LevelGlyphsRst;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_FULL_SCALE:   cfg_full_scale_q   <= cfg_data_i[LevelW-1:0];
        REG_CELL_COUNT:   cfg_cell_count_q   <= cfg_data_i[CountW-1:0];
        REG_EMPTY_GLYPH:  cfg_empty_glyph_q  <= cfg_data_i[GlyphW-1:0];
        REG_LEVEL_GLYPHS: cfg_level_glyphs_q <= cfg_data_i[GlyphsW-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer and datapath state
  lbg_state_e state_q, state_d;

  logic [LevelW-1:0] level_q;
  logic [NW-1:0]     n_q;
  logic [SpanW-1:0]  span_q;
  logic [SpanW-1:0]  rem_q;     // divider remainder, r after the last step
  logic [LevelW-1:0] quo_q;     // dividend shifting out, q after the last step
  logic [CntW-1:0]   cnt_q;
  logic [ThrW-1:0]   base_q;    // lower edge of the current cell
  logic [ThrW-1:0]   qc_q;      // q * CELL_COLUMNS, width of one cell
  logic [NW-1:0]     cell_q;
  logic              ended_q;

  logic              out_valid_q;
  logic [GlyphW-1:0] glyph_q;
  logic [NW-1:0]     idx_q;
  logic              last_q;

  // Clamp of the cell count
  logic [NW-1:0] n_eff;
  always_comb begin
    if (32'(cfg_cell_count_q) > 32'(MAX_CELLS)) begin
      n_eff = NW'(MAX_CELLS);
    end else begin
      n_eff = NW'(cfg_cell_count_q);
    end
  end

  logic in_take;
  assign in_take = in_valid_i && in_ready_o;

  // Shared subtractor: one restoring division step per cycle
  logic [SpanW:0]   trial;
  logic             div_ge;
  logic [SpanW-1:0] rem_d;
  assign trial  = {rem_q, quo_q[LevelW-1]};
  assign div_ge = trial >= {1'b0, span_q};
  assign rem_d  = div_ge ? SpanW'(trial - {1'b0, span_q}) : SpanW'(trial);

  // Cell decision: full test and partial-step search over the columns
  logic [ThrW-1:0] lvl_ext;
  logic [ThrW-1:0] q_ext;
  logic            cell_full;
  logic            part_found;
  logic [BW-1:0]   part_b;
  logic            zero_first;
  logic [GlyphW-1:0] glyph_now;
  logic            end_now;
  logic            last_now;

  assign lvl_ext  = ThrW'(level_q);
  assign q_ext    = ThrW'(quo_q);
  assign cell_full = lvl_ext >= ThrW'(base_q + qc_q);
  assign zero_first = (cell_q == '0) && (level_q == '0);
  assign last_now  = cell_q == NW'(n_q - 1'b1);

  always_comb begin
    part_found = 1'b0;
    part_b     = '0;
    // descending so the smallest matching step wins
    for (int m = CELL_COLUMNS; m >= 1; m--) begin
      if (lvl_ext < ThrW'(base_q + ThrW'(m) * q_ext)) begin
        part_found = 1'b1;
        part_b     = BW'(m - 1);
      end
    end
  end

  always_comb begin
    glyph_now = cfg_empty_glyph_q;
    end_now   = 1'b0;
    if (!ended_q) begin
      if (cell_full) begin
        glyph_now = glyph_sel(cfg_level_glyphs_q, 4'(CELL_COLUMNS - 1));
      end else if (zero_first) begin
        end_now = 1'b1;
      end else if (part_found) begin
        glyph_now = glyph_sel(cfg_level_glyphs_q, 4'(part_b));
        end_now   = 1'b1;
      end
    end
  end

  // Outputs of the sequencer
  logic emit_load;
  always_comb begin
    in_ready_o = 1'b0;
    emit_load  = 1'b0;
    case (state_q)
      ST_IDLE: in_ready_o = 1'b1;
      ST_EMIT: emit_load  = !out_valid_q || out_ready_i;
      default: ;
    endcase
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (in_valid_i && n_eff != '0) state_d = ST_DIV;
      ST_DIV:   if (cnt_q == CntW'(DivSteps - 1)) state_d = ST_SETUP;
      ST_SETUP: state_d = ST_EMIT;
      ST_EMIT:  if (emit_load && last_now) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      ended_q     <= 1'b0;
    end else begin
      state_q <= state_d;
      if (emit_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (state_q == ST_SETUP) begin
        ended_q <= 1'b0;
      end else if (emit_load) begin
        ended_q <= ended_q | end_now;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (in_take) begin
          level_q <= level_i;
          n_q     <= n_eff;
          span_q  <= SpanW'(int'(n_eff) * CELL_COLUMNS);
          rem_q   <= '0;
          quo_q   <= cfg_full_scale_q;
          cnt_q   <= '0;
        end
      end
      ST_DIV: begin
        rem_q <= rem_d;
        quo_q <= {quo_q[LevelW-2:0], div_ge};
        cnt_q <= cnt_q + 1'b1;
      end
      ST_SETUP: begin
        base_q <= ThrW'(rem_q);
        qc_q   <= ThrW'(ThrW'(quo_q) * ThrW'(CELL_COLUMNS));
        cell_q <= '0;
      end
      ST_EMIT: begin
        if (emit_load) begin
          glyph_q <= glyph_now;
          idx_q   <= cell_q;
          last_q  <= last_now;
          cell_q  <= cell_q + 1'b1;
          base_q  <= ThrW'(base_q + qc_q);
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o  = out_valid_q;
  assign cell_glyph_o = glyph_q;
  assign cell_index_o = CellIdxW'(idx_q);
  assign last_cell_o  = last_q;

  // Divider remainder stays below the span throughout the division
  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> (rem_q < span_q))
    else $error("divider remainder out of range");

  // Emitter never runs past the bar
  a_cell_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT) |-> (cell_q < n_q))
    else $error("cell counter beyond cell count");

  // A cell handed over that is not the last moves on to the next cell
  a_cell_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit_load && !last_now) |=> (state_q == ST_EMIT && cell_q == NW'($past(cell_q) + 1'b1)))
    else $error("cell sequence broken");

  // Last cell leaves the sequencer idle
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit_load && last_now) |=> (state_q == ST_IDLE && out_valid_q && last_q))
    else $error("sequencer not idle after last cell");

endmodule
`default_nettype wire
